// ===== src/gbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared constants and types of the grid best-first passage core.
// ----------------------------------------------------------------------------
package gbfp_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // character codes
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_UPR_A = 8'h41;
   localparam logic [7:0] CH_UPR_Z = 8'h5A;

   // back-pointer codes: the step to take from a cell towards its parent
   localparam logic [2:0] DIR_XP    = 3'd0;
   localparam logic [2:0] DIR_YP    = 3'd1;
   localparam logic [2:0] DIR_XN    = 3'd2;
   localparam logic [2:0] DIR_YN    = 3'd3;
   localparam logic [2:0] DIR_START = 3'd4;
   localparam logic [2:0] DIR_NONE  = 3'd7;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CARVE = 2'd2;

   // csr register select (paddr bit 2)
   localparam logic CSR_SEL_WIDTH  = 1'b0;
   localparam logic CSR_SEL_HEIGHT = 1'b1;

   typedef struct packed {
      logic clr;
      logic push;
      logic pop;
   } heap_ctrl_type;

   typedef struct packed {
      logic busy;
      logic empty;
   } heap_stat_type;

   function automatic logic is_wall(input logic [7:0] c);
      return (c >= CH_UPR_A) && (c <= CH_UPR_Z);
   endfunction

endpackage

// ===== src/gbfp_ram.sv =====
// ----------------------------------------------------------------------------
// gbfp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gbfp_heap.sv =====
// ----------------------------------------------------------------------------
// gbfp_heap
// Binary min-heap of search keys held in one RAM; push sifts up, pop sifts
// down, one RAM read per cycle.
// ----------------------------------------------------------------------------
module gbfp_heap #(
   parameter int KEY_W = 32,
   parameter int DEPTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbfp_pkg::heap_ctrl_type ctrl,
   input  logic [KEY_W-1:0]       push_key,
   output gbfp_pkg::heap_stat_type stat,
   output logic [KEY_W-1:0]       top_key
);

   localparam int AW = $clog2(DEPTH);

   typedef enum logic [3:0] {
      HS_IDLE, HS_PUSH_RD, HS_PUSH_CMP, HS_POP_TOP, HS_POP_LAST,
      HS_SIFT_RD, HS_SIFT_A, HS_SIFT_B, HS_SIFT_CMP, HS_SIFT_FIN
   } hstate_type;

   hstate_type       state_ff, state_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    cpos_ff, cpos_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] top_ff, top_in;
   logic [KEY_W-1:0] last_ff, last_in;
   logic [KEY_W-1:0] cand_ff, cand_in;

   logic             we;
   logic [AW-1:0]    waddr, raddr;
   logic [KEY_W-1:0] wdata, rdata;
   logic [AW:0]      child, child2;
   logic [AW-1:0]    up;

   gbfp_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign child  = {pos_ff, 1'b1};
   assign child2 = child + (AW+1)'(1);
   assign up     = AW'((pos_ff - AW'(1)) >> 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      cpos_in  = cpos_ff;
      key_in   = key_ff;
      top_in   = top_ff;
      last_in  = last_ff;
      cand_in  = cand_ff;
      we       = 1'b0;
      waddr    = pos_ff;
      wdata    = key_ff;
      raddr    = '0;
      case (state_ff)
         HS_IDLE: begin
            if (ctrl.clr) begin
               cnt_in = '0;
            end else if (ctrl.push) begin
               pos_in   = cnt_ff[AW-1:0];
               cnt_in   = cnt_ff + (AW+1)'(1);
               key_in   = push_key;
               state_in = HS_PUSH_RD;
            end else if (ctrl.pop) begin
               cnt_in   = cnt_ff - (AW+1)'(1);
               state_in = HS_POP_TOP;
            end
         end
         HS_PUSH_RD: begin
            if (pos_ff == '0) begin
               we       = 1'b1;
               state_in = HS_IDLE;
            end else begin
               raddr    = up;
               state_in = HS_PUSH_CMP;
            end
         end
         HS_PUSH_CMP: begin
            we = 1'b1;
            if (rdata <= key_ff) begin
               state_in = HS_IDLE;
            end else begin
               wdata    = rdata;
               pos_in   = up;
               state_in = HS_PUSH_RD;
            end
         end
         HS_POP_TOP: begin
            top_in   = rdata;
            raddr    = cnt_ff[AW-1:0];
            state_in = HS_POP_LAST;
         end
         HS_POP_LAST: begin
            last_in  = rdata;
            pos_in   = '0;
            state_in = HS_SIFT_RD;
         end
         HS_SIFT_RD: begin
            if (child >= cnt_ff) begin
               state_in = HS_SIFT_FIN;
            end else begin
               raddr    = child[AW-1:0];
               state_in = HS_SIFT_A;
            end
         end
         HS_SIFT_A: begin
            cand_in = rdata;
            cpos_in = child[AW-1:0];
            if (child2 < cnt_ff) begin
               raddr    = child2[AW-1:0];
               state_in = HS_SIFT_B;
            end else begin
               state_in = HS_SIFT_CMP;
            end
         end
         HS_SIFT_B: begin
            if (rdata < cand_ff) begin
               cand_in = rdata;
               cpos_in = child2[AW-1:0];
            end
            state_in = HS_SIFT_CMP;
         end
         HS_SIFT_CMP: begin
            if (last_ff <= cand_ff) begin
               state_in = HS_SIFT_FIN;
            end else begin
               we       = 1'b1;
               wdata    = cand_ff;
               pos_in   = cpos_ff;
               state_in = HS_SIFT_RD;
            end
         end
         HS_SIFT_FIN: begin
            we       = (cnt_ff != '0);
            wdata    = last_ff;
            state_in = HS_IDLE;
         end
         default: state_in = HS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff  <= pos_in;
      cpos_ff <= cpos_in;
      key_ff  <= key_in;
      top_ff  <= top_in;
      last_ff <= last_in;
      cand_ff <= cand_in;
   end

   assign stat.busy  = (state_ff != HS_IDLE);
   assign stat.empty = (cnt_ff == '0);
   assign top_key    = top_ff;

endmodule

// ===== src/grid_best_first_passage_core.sv =====
// ----------------------------------------------------------------------------
// grid_best_first_passage_core
// Character grid with cell load/read and greedy best-first passage carving.
// ----------------------------------------------------------------------------
// Items are taken with start while busy is low; each item gives exactly one
// result, strobed by rsp_valid for one cycle, which the receiver cannot hold
// off. After reset the cell RAM is swept to '#' with busy high. A write gives
// its result the next cycle and busy stays low; a read passes through the
// S_READ state first. A carve first sweeps the cell RAM once to clear the
// back-pointers, then loops: a heap pop, and per neighbour a cell read, check
// and, for an open unvisited cell, a heap push; the trace-back reads and
// carves the path cells one by one. The single read port of the cell RAM and
// of the heap RAM sets the pace.
// Cell state (character plus 3-bit back-pointer) lives in one RAM, the open
// list in a second. Config: width at byte 0, height at byte 4.
// ----------------------------------------------------------------------------
module grid_best_first_passage_core #(
   parameter int MAX_WIDTH  = gbfp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gbfp_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   // item transfer
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [7:0]  req_cell_char,
   input  logic [5:0]  req_start_x,
   input  logic [5:0]  req_start_y,
   input  logic [5:0]  req_finish_x,
   input  logic [5:0]  req_finish_y,
   // result transfer
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_char,
   output logic        rsp_path_found,
   output logic [12:0] rsp_carved_count,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int CELLS = 1 << AW;
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CW    = ((XW > YW) ? XW : YW) + 1;
   localparam int KW    = CW + AW + AW;
   localparam int MW    = 11;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_READ, S_CLR, S_LOOP, S_POPW,
      S_NB, S_NB_CHK, S_NB_WAIT, S_TRACE, S_TR_RD
   } state_type;

   // configuration registers
   logic [6:0] width_ff, height_ff;
   logic       csr_wr;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == gbfp_pkg::CSR_SEL_HEIGHT) ?
                       {25'd0, height_ff} : {25'd0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
      end else if (csr_wr) begin
         if (csr_paddr[2] == gbfp_pkg::CSR_SEL_WIDTH) begin
            width_ff <= csr_pwdata[6:0];
         end else begin
            height_ff <= csr_pwdata[6:0];
         end
      end
   end

   // grid size in use, clamped to 1..MAX
   logic [DW-1:0] wdim;
   logic [HW-1:0] hdim;

   assign wdim = (width_ff == '0) ? DW'(1) :
                 ((int'(width_ff) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_ff));
   assign hdim = (height_ff == '0) ? HW'(1) :
                 ((int'(height_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_ff));

   // control and payload state
   state_type     state_ff, state_in;
   logic [AW:0]   addr_ff, addr_in;
   logic [XW-1:0] fx_ff, fx_in;
   logic [YW-1:0] fy_ff, fy_in;
   logic [AW-1:0] sidx_ff, sidx_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] nidx_ff, nidx_in;
   logic [1:0]    dir_ff, dir_in;
   logic [AW-1:0] seq_ff, seq_in;
   logic [12:0]   cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [12:0]   rsp_count_ff, rsp_count_in;

   // cell RAM: {back-pointer, character}, address {y, x}
   logic          m_we;
   logic [AW-1:0] m_waddr, m_raddr;
   logic [MW-1:0] m_wdata, m_rdata;

   gbfp_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_cells (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata)
   );

   // open list
   gbfp_pkg::heap_ctrl_type hctrl;
   gbfp_pkg::heap_stat_type hstat;
   logic [KW-1:0]           hkey, htop;

   gbfp_heap #(.KEY_W(KW), .DEPTH(CELLS)) u_heap (
      .clock(clock), .reset(reset), .ctrl(hctrl), .push_key(hkey),
      .stat(hstat), .top_key(htop)
   );

   // request decode
   logic          cell_in_grid, ends_in_grid;
   logic [AW-1:0] cell_addr;
   logic [AW-1:0] req_sidx;

   assign cell_in_grid = (int'(req_cell_x) < int'(wdim)) &&
                         (int'(req_cell_y) < int'(hdim));
   assign ends_in_grid = (int'(req_start_x) < int'(wdim)) &&
                         (int'(req_start_y) < int'(hdim)) &&
                         (int'(req_finish_x) < int'(wdim)) &&
                         (int'(req_finish_y) < int'(hdim));
   assign cell_addr    = {YW'(req_cell_y), XW'(req_cell_x)};
   assign req_sidx     = {YW'(req_start_y), XW'(req_start_x)};

   // current cell and neighbour under test
   logic [XW-1:0] cur_x, nb_x;
   logic [YW-1:0] cur_y, nb_y;
   logic          nb_ok;
   logic [CW-1:0] nb_cost, start_cost;
   logic [XW-1:0] adx, sdx;
   logic [YW-1:0] ady, sdy;
   logic [7:0]    rd_char;
   logic [2:0]    rd_dir;
   logic          carvable;

   assign cur_x = cur_ff[XW-1:0];
   assign cur_y = cur_ff[AW-1:XW];

   always_comb begin
      nb_x  = cur_x;
      nb_y  = cur_y;
      nb_ok = 1'b0;
      case (dir_ff)
         gbfp_pkg::DIR_XP[1:0]: begin
            nb_ok = (cur_x != '0);
            nb_x  = cur_x - XW'(1);
         end
         gbfp_pkg::DIR_YP[1:0]: begin
            nb_ok = (cur_y != '0);
            nb_y  = cur_y - YW'(1);
         end
         gbfp_pkg::DIR_XN[1:0]: begin
            nb_ok = ((DW'(cur_x) + DW'(1)) < wdim);
            nb_x  = cur_x + XW'(1);
         end
         default: begin
            nb_ok = ((HW'(cur_y) + HW'(1)) < hdim);
            nb_y  = cur_y + YW'(1);
         end
      endcase
   end

   assign adx     = (nb_x > fx_ff) ? (nb_x - fx_ff) : (fx_ff - nb_x);
   assign ady     = (nb_y > fy_ff) ? (nb_y - fy_ff) : (fy_ff - nb_y);
   assign nb_cost = CW'(adx) + CW'(ady);

   assign sdx = (XW'(req_start_x) > XW'(req_finish_x)) ?
                (XW'(req_start_x) - XW'(req_finish_x)) :
                (XW'(req_finish_x) - XW'(req_start_x));
   assign sdy = (YW'(req_start_y) > YW'(req_finish_y)) ?
                (YW'(req_start_y) - YW'(req_finish_y)) :
                (YW'(req_finish_y) - YW'(req_start_y));
   assign start_cost = CW'(sdx) + CW'(sdy);

   assign rd_char  = m_rdata[7:0];
   assign rd_dir   = m_rdata[10:8];
   assign carvable = (rd_char != gbfp_pkg::CH_STAR) && (rd_char != gbfp_pkg::CH_GT) &&
                     (rd_char != gbfp_pkg::CH_SPACE) && !gbfp_pkg::is_wall(rd_char);

   // start cost is held for the push that closes the clearing sweep
   logic [CW-1:0] scost_ff, scost_in;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      sidx_in      = sidx_ff;
      cur_in       = cur_ff;
      nidx_in      = nidx_ff;
      dir_in       = dir_ff;
      seq_in       = seq_ff;
      cnt_in       = cnt_ff;
      scost_in     = scost_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = '0;
      rsp_found_in = 1'b0;
      rsp_count_in = '0;
      m_we         = 1'b0;
      m_waddr      = cur_ff;
      m_wdata      = {gbfp_pkg::DIR_NONE, gbfp_pkg::CH_HASH};
      m_raddr      = cur_ff;
      hctrl        = '0;
      hkey         = {nb_cost, seq_ff, nidx_ff};
      case (state_ff)
         S_INIT: begin
            m_we    = 1'b1;
            m_waddr = addr_ff[AW-1:0];
            addr_in = addr_ff + (AW+1)'(1);
            if (addr_ff[AW-1:0] == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            m_raddr = cell_addr;
            if (start) begin
               case (req_func)
                  gbfp_pkg::FUNC_WRITE: begin
                     m_we         = cell_in_grid;
                     m_waddr      = cell_addr;
                     m_wdata      = {gbfp_pkg::DIR_NONE, req_cell_char};
                     rsp_valid_in = 1'b1;
                  end
                  gbfp_pkg::FUNC_READ: begin
                     if (cell_in_grid) begin
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  gbfp_pkg::FUNC_CARVE: begin
                     if (ends_in_grid) begin
                        fx_in     = XW'(req_finish_x);
                        fy_in     = YW'(req_finish_y);
                        sidx_in   = req_sidx;
                        scost_in  = start_cost;
                        addr_in   = '0;
                        seq_in    = '0;
                        cnt_in    = '0;
                        hctrl.clr = 1'b1;
                        state_in  = S_CLR;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = rd_char;
            state_in     = S_IDLE;
         end
         S_CLR: begin
            // read entry n while writing back entry n-1 with its pointer reset, or set to start for the start cell
            m_raddr = addr_ff[AW-1:0];
            m_waddr = AW'(addr_ff - (AW+1)'(1));
            m_we    = (addr_ff != '0);
            m_wdata = {((m_waddr == sidx_ff) ? gbfp_pkg::DIR_START : gbfp_pkg::DIR_NONE),
                       rd_char};
            addr_in = addr_ff + (AW+1)'(1);
            if (addr_ff == (AW+1)'(CELLS)) begin
               hctrl.push = 1'b1;
               hkey       = {scost_ff, seq_ff, sidx_ff};
               seq_in     = seq_ff + AW'(1);
               state_in   = S_LOOP;
            end
         end
         S_LOOP: begin
            if (!hstat.busy) begin
               if (hstat.empty) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  hctrl.pop = 1'b1;
                  state_in  = S_POPW;
               end
            end
         end
         S_POPW: begin
            if (!hstat.busy) begin
               cur_in = htop[AW-1:0];
               dir_in = gbfp_pkg::DIR_XP[1:0];
               if (htop[AW-1:0] == {fy_ff, fx_ff}) begin
                  state_in = S_TRACE;
               end else begin
                  state_in = S_NB;
               end
            end
         end
         S_NB: begin
            m_raddr = {nb_y, nb_x};
            nidx_in = {nb_y, nb_x};
            if (nb_ok) begin
               state_in = S_NB_CHK;
            end else if (dir_ff == gbfp_pkg::DIR_YN[1:0]) begin
               state_in = S_LOOP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NB_CHK: begin
            if (!gbfp_pkg::is_wall(rd_char) && (rd_dir == gbfp_pkg::DIR_NONE)) begin
               m_we       = 1'b1;
               m_waddr    = nidx_ff;
               m_wdata    = {1'b0, dir_ff, rd_char};
               hctrl.push = 1'b1;
               seq_in     = seq_ff + AW'(1);
               state_in   = S_NB_WAIT;
            end else if (dir_ff == gbfp_pkg::DIR_YN[1:0]) begin
               state_in = S_LOOP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_NB;
            end
         end
         S_NB_WAIT: begin
            if (!hstat.busy) begin
               if (dir_ff == gbfp_pkg::DIR_YN[1:0]) begin
                  state_in = S_LOOP;
               end else begin
                  dir_in   = dir_ff + 2'd1;
                  state_in = S_NB;
               end
            end
         end
         S_TRACE: begin
            m_raddr = cur_ff;
            if (cur_ff == sidx_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_count_in = cnt_ff;
               state_in     = S_IDLE;
            end else begin
               state_in = S_TR_RD;
            end
         end
         S_TR_RD: begin
            m_waddr  = cur_ff;
            m_wdata  = {rd_dir, gbfp_pkg::CH_SPACE};
            m_we     = carvable;
            cnt_in   = cnt_ff + (carvable ? 13'd1 : 13'd0);
            state_in = S_TRACE;
            case (rd_dir)
               gbfp_pkg::DIR_XP: cur_in = {cur_y, cur_x + XW'(1)};
               gbfp_pkg::DIR_YP: cur_in = {cur_y + YW'(1), cur_x};
               gbfp_pkg::DIR_XN: cur_in = {cur_y, cur_x - XW'(1)};
               gbfp_pkg::DIR_YN: cur_in = {cur_y - YW'(1), cur_x};
               default: begin
                  // broken chain: finish as found with what is carved so far
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  rsp_count_in = cnt_in;
                  state_in     = S_IDLE;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      sidx_ff      <= sidx_in;
      cur_ff       <= cur_in;
      nidx_ff      <= nidx_in;
      dir_ff       <= dir_in;
      seq_ff       <= seq_in;
      cnt_ff       <= cnt_in;
      scost_ff     <= scost_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_char    = rsp_char_ff;
   assign rsp_path_found   = rsp_found_ff;
   assign rsp_carved_count = rsp_count_ff;

endmodule

// ===== src/gbfp_checker.sv =====
// ----------------------------------------------------------------------------
// gbfp_checker
// Port-level checks of the passage core, bound to the top level.
// ----------------------------------------------------------------------------
module gbfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic [7:0]  rsp_read_char,
   input logic        rsp_path_found,
   input logic [12:0] rsp_carved_count,
   input logic        csr_pready
);

   // a write transfer answers in the very next cycle
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == gbfp_pkg::FUNC_WRITE) |=> rsp_valid)
      else $error("write transfer gave no result next cycle");

   // the clearing sweep holds off items right after reset
   a_init_busy: assert property (@(posedge clock)
      !reset && $past(reset) |-> busy)
      else $error("core not busy after reset");

   // nothing carved unless a path was found
   a_count_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_path_found |-> (rsp_carved_count == '0))
      else $error("carved count without a path");

   // a read result carries no carve status
   a_read_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_char != '0) |-> !rsp_path_found)
      else $error("read and carve results mixed");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready dropped");

endmodule

bind grid_best_first_passage_core gbfp_checker u_gbfp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_func(req_func), .rsp_valid(rsp_valid), .rsp_read_char(rsp_read_char),
   .rsp_path_found(rsp_path_found), .rsp_carved_count(rsp_carved_count),
   .csr_pready(csr_pready)
);

// ===== dv/gbfp_checker.sv =====
// ----------------------------------------------------------------------------
// tb_gbfp_checker
// Watches the item, result and csr transfers of the passage core, predicts
// each result and compares it with what the core returns.
// ----------------------------------------------------------------------------
module tb_gbfp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [7:0]  req_cell_char,
   input  logic [5:0]  req_start_x,
   input  logic [5:0]  req_start_y,
   input  logic [5:0]  req_finish_x,
   input  logic [5:0]  req_finish_y,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_read_char,
   input  logic        rsp_path_found,
   input  logic [12:0] rsp_carved_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS  = gbfp_pkg::DEF_MAX_WIDTH;
   localparam int ROWS  = gbfp_pkg::DEF_MAX_HEIGHT;
   localparam int CELLS = COLS * ROWS;

   typedef struct packed {
      logic [7:0]  read_char;
      logic        path_found;
      logic [12:0] carved_count;
   } outcome_type;

   // neighbour offsets; a neighbour sits at cell minus offset, parent at plus
   localparam int STEP_X [4] = '{1, 0, -1, 0};
   localparam int STEP_Y [4] = '{0, 1, 0, -1};

   logic [7:0]  grid_chars [CELLS];
   logic [2:0]  back_dir   [CELLS];
   logic [63:0] open_keys  [CELLS + 1];
   int          open_count;
   int          push_seq;
   logic [6:0]  width_reg, height_reg;
   outcome_type expected_q [$];

   assign pending = expected_q.size();

   function automatic int clamp_size(input logic [6:0] v, input int hi);
      if (v == 0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   function automatic bit blocks(input logic [7:0] c);
      return c >= gbfp_pkg::CH_UPR_A && c <= gbfp_pkg::CH_UPR_Z;
   endfunction

   function automatic int manhattan(input int ax, ay, bx, by);
      return (ax > bx ? ax - bx : bx - ax) + (ay > by ? ay - by : by - ay);
   endfunction

   function automatic void open_push(input int cost, input int idx);
      open_keys[open_count] = {4'd0, 20'(cost), 20'(push_seq), 20'(idx)};
      open_count++;
      push_seq++;
   endfunction

   // keys are unique, so taking the minimum matches heap order exactly
   function automatic int open_pop();
      int best;
      int idx;
      best = 0;
      for (int k = 1; k < open_count; k++)
         if (open_keys[k] < open_keys[best]) best = k;
      idx = int'(open_keys[best][19:0]);
      open_count--;
      open_keys[best] = open_keys[open_count];
      return idx;
   endfunction

   function automatic outcome_type carve_passage(input int sx, sy, fx, fy);
      outcome_type r;
      int w, h, sidx, fidx, cur, nx, ny, nidx, cnt, d;
      bit found;
      r = '0;
      w = clamp_size(width_reg, COLS);
      h = clamp_size(height_reg, ROWS);
      found = 0;
      cnt = 0;
      if (sx >= w || sy >= h || fx >= w || fy >= h) return r;
      foreach (back_dir[k]) back_dir[k] = gbfp_pkg::DIR_NONE;
      open_count = 0;
      push_seq = 0;
      sidx = sy * COLS + sx;
      fidx = fy * COLS + fx;
      back_dir[sidx] = gbfp_pkg::DIR_START;
      open_push(manhattan(sx, sy, fx, fy), sidx);
      while (open_count > 0) begin
         cur = open_pop();
         if (cur == fidx) begin
            found = 1;
            break;
         end
         for (int i = 0; i < 4; i++) begin
            nx = cur % COLS - STEP_X[i];
            ny = cur / COLS - STEP_Y[i];
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
            nidx = ny * COLS + nx;
            if (blocks(grid_chars[nidx]) || back_dir[nidx] != gbfp_pkg::DIR_NONE) continue;
            back_dir[nidx] = 3'(i);
            open_push(manhattan(nx, ny, fx, fy), nidx);
         end
      end
      if (!found) return r;
      // trace back to start, clearing ordinary cells
      cur = fidx;
      for (int g = 0; cur != sidx && g < CELLS; g++) begin
         if (grid_chars[cur] != gbfp_pkg::CH_STAR && grid_chars[cur] != gbfp_pkg::CH_GT &&
             !blocks(grid_chars[cur]) && grid_chars[cur] != gbfp_pkg::CH_SPACE) begin
            grid_chars[cur] = gbfp_pkg::CH_SPACE;
            cnt++;
         end
         d = int'(back_dir[cur]);
         if (d > 3) break;
         nx = cur % COLS + STEP_X[d];
         ny = cur / COLS + STEP_Y[d];
         if (nx < 0 || ny < 0 || nx >= COLS || ny >= ROWS) break;
         cur = ny * COLS + nx;
      end
      r.path_found   = 1'b1;
      r.carved_count = 13'(cnt);
      return r;
   endfunction

   function automatic outcome_type predict_item();
      outcome_type r;
      int w, h, cidx;
      r = '0;
      w = clamp_size(width_reg, COLS);
      h = clamp_size(height_reg, ROWS);
      cidx = int'(req_cell_y) * COLS + int'(req_cell_x);
      case (req_func)
         gbfp_pkg::FUNC_WRITE: begin
            if (req_cell_x < w && req_cell_y < h) grid_chars[cidx] = req_cell_char;
         end
         gbfp_pkg::FUNC_READ: begin
            if (req_cell_x < w && req_cell_y < h) r.read_char = grid_chars[cidx];
         end
         gbfp_pkg::FUNC_CARVE: begin
            r = carve_passage(req_start_x, req_start_y, req_finish_x, req_finish_y);
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (grid_chars[k]) grid_chars[k] = gbfp_pkg::CH_HASH;
         width_reg  = 7'd64;
         height_reg = 7'd64;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == gbfp_pkg::CSR_SEL_HEIGHT) height_reg = csr_pwdata[6:0];
            else                                          width_reg  = csr_pwdata[6:0];
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result with nothing expected, actual %h/%b/%0d", $realtime,
                        rsp_read_char, rsp_path_found, rsp_carved_count);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (want.read_char !== rsp_read_char) begin
                  $display("%0t: read_char expected %h actual %h", $realtime,
                           want.read_char, rsp_read_char);
                  fail_count++;
               end
               if (want.path_found !== rsp_path_found) begin
                  $display("%0t: path_found expected %b actual %b", $realtime,
                           want.path_found, rsp_path_found);
                  fail_count++;
               end
               if (want.carved_count !== rsp_carved_count) begin
                  $display("%0t: carved_count expected %0d actual %0d", $realtime,
                           want.carved_count, rsp_carved_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) expected_q.insert(expected_q.size(), predict_item());
      end
   end

endmodule

// ===== dv/tb_grid_best_first_passage_core.sv =====
// ----------------------------------------------------------------------------
// tb_grid_best_first_passage_core
// Drives write, read and carve items through several grid sizes and lets
// the checker compare every result with its own prediction.
// ----------------------------------------------------------------------------
module tb_grid_best_first_passage_core;
   timeunit 1ns;
   timeprecision 1ps;

   // the one func code with no operation behind it
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = gbfp_pkg::FUNC_WRITE;
   logic [5:0]  req_cell_x = '0, req_cell_y = '0;
   logic [7:0]  req_cell_char = '0;
   logic [5:0]  req_start_x = '0, req_start_y = '0;
   logic [5:0]  req_finish_x = '0, req_finish_y = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_char;
   logic        rsp_path_found;
   logic [12:0] rsp_carved_count;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   // grid size currently in use, for shaping the random carves
   int          cur_w = 64, cur_h = 64;

   always #1 clock = ~clock;

   grid_best_first_passage_core i_dut (.*);

   tb_gbfp_checker i_checker (.*);

   // hand one item over; idle cycles before it keep start low
   task automatic send_item(input logic [1:0] fn, input int cx, cy, ch,
                            input int sx, sy, fx, fy, input int idle);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= fn;
      req_cell_x    <= 6'(cx);
      req_cell_y    <= 6'(cy);
      req_cell_char <= 8'(ch);
      req_start_x   <= 6'(sx);
      req_start_y   <= 6'(sy);
      req_finish_x  <= 6'(fx);
      req_finish_y  <= 6'(fy);
      // transfer happens at the first edge that sees busy low
      do @(posedge clock); while (busy);
   endtask

   task automatic send_quick(input logic [1:0] fn, input int cx, cy, ch,
                             input int sx, sy, fx, fy);
      send_item(fn, cx, cy, ch, sx, sy, fx, fy, $urandom_range(0, 3));
   endtask

   // stop issuing and wait until every result is back
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic csr_write(input logic sel, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_grid(input int w, h);
      drain();
      csr_write(gbfp_pkg::CSR_SEL_WIDTH, w);
      csr_write(gbfp_pkg::CSR_SEL_HEIGHT, h);
      cur_w = (w == 0) ? 1 : (w > 64 ? 64 : w);
      cur_h = (h == 0) ? 1 : (h > 64 ? 64 : h);
   endtask

   // floor and walls half the time, with the protected marks and raw bytes mixed in
   function automatic int pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'h2E;
         3, 4:    return $urandom_range(gbfp_pkg::CH_UPR_A, gbfp_pkg::CH_UPR_Z);
         5:       return gbfp_pkg::CH_SPACE;
         6:       return gbfp_pkg::CH_STAR;
         7:       return gbfp_pkg::CH_GT;
         8:       return gbfp_pkg::CH_HASH;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // coordinate inside the grid most of the time, anywhere now and then
   function automatic int pick_coord(input int lim);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, lim - 1);
   endfunction

   // wall letter 'Q'
   function automatic int wall_q();
      return gbfp_pkg::CH_UPR_A + 16;
   endfunction

   task automatic random_item();
      int sel;
      int idle;
      sel  = $urandom_range(0, 19);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (sel < 10)
         send_item(gbfp_pkg::FUNC_WRITE, pick_coord(cur_w), pick_coord(cur_h), pick_char(),
                   $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63), idle);
      else if (sel < 13)
         send_item(gbfp_pkg::FUNC_READ, pick_coord(cur_w), pick_coord(cur_h),
                   $urandom_range(0, 255), 0, 0, 0, 0, idle);
      else if (sel < 19)
         send_item(gbfp_pkg::FUNC_CARVE, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), pick_coord(cur_w), pick_coord(cur_h),
                   pick_coord(cur_w), pick_coord(cur_h), idle);
      else
         send_item(FUNC_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), 0, 0, 0, 0, idle);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed, default 64x64 grid ---
      send_quick(gbfp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 63, 63, gbfp_pkg::CH_UPR_A, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 0, 0, 8'hFF, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 5, 0, gbfp_pkg::CH_STAR, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 3, 0, gbfp_pkg::CH_GT, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 2, 0, gbfp_pkg::CH_SPACE, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 7, 0, gbfp_pkg::CH_UPR_Z, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_READ, 63, 63, 0, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
      send_quick(FUNC_SPARE, 63, 63, 255, 63, 63, 63, 63);
      // start equal to finish: found with nothing carved
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 4, 4, 4, 4);
      // row with protected marks, a space and a wall start
      send_quick(gbfp_pkg::FUNC_WRITE, 9, 0, wall_q(), 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 9, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 0, 0, 62, 63);
      send_quick(gbfp_pkg::FUNC_READ, 1, 0, 0, 0, 0, 0, 0);

      // --- 1x1 grid from zero-sized registers ---
      set_grid(0, 0);
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_WRITE, 1, 0, gbfp_pkg::CH_STAR, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_READ, 1, 0, 0, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 0, 0, 1, 0);

      // --- oversize width, height of 4; finish on a wall is never reached ---
      set_grid(127, 4);
      send_quick(gbfp_pkg::FUNC_WRITE, 63, 3, gbfp_pkg::CH_UPR_A, 0, 0, 0, 0);
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 0, 3, 63, 3);
      send_quick(gbfp_pkg::FUNC_CARVE, 0, 0, 0, 0, 3, 62, 3);
      send_quick(gbfp_pkg::FUNC_READ, 63, 4, 0, 0, 0, 0, 0);

      // --- random phases; each phase drains before the size changes ---
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       set_grid(1, 12);
            1:       set_grid(64, 6);
            2:       set_grid(12, 1);
            default: set_grid($urandom_range(3, 12), $urandom_range(3, 12));
         endcase
         // random items of every kind, in two runs
         for (int k = 0; k < 4; k++) random_item();
         repeat (9) random_item();
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
